// ----- design/phh_pkg.sv -----
// ----------------------------------------------------------------------------
// phh_pkg
// Types and constants shared by the pulse-height histogram modules.
// ----------------------------------------------------------------------------
package phh_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int BIN_IDX_W = 8;
  localparam int COUNT_W   = 32;
  localparam int TAKEN_W   = 16;
  // widest bin address over the parameter range
  localparam int ADDR_W    = 12;

  localparam logic [TAKEN_W-1:0] LIMIT_RESET = 16'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_READ   = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [BIN_IDX_W-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [TAKEN_W-1:0] samples_taken;
    logic               measurement_done;
    logic               sample_accepted;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_INC,
    OP_READ,
    OP_ZERO
  } op_kind_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [ADDR_W-1:0]  addr;
    logic [TAKEN_W-1:0] samples_taken;
    logic               done;
    logic               accepted;
  } op_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_WB
  } back_state_e;

endpackage

// ----- design/phh_front.sv -----
// ----------------------------------------------------------------------------
// phh_front
// Takes items, holds the limit register and sample counter, works out the
// bin and turns each item into a memory operation for the back end.
// ----------------------------------------------------------------------------
module phh_front #(
  parameter int BIN_COUNT   = 256,
  parameter int SAMPLE_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  phh_pkg::in_item_t in_data_i,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data_i,
  input  logic              q_full_i,
  input  logic              clearing_i,
  output logic              push_o,
  output phh_pkg::op_t      op_o
);
  import phh_pkg::*;

  localparam int VW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CW = $clog2(BIN_COUNT + 1);
  localparam int PW = VW + CW;
  localparam int BW = $clog2(BIN_COUNT);

  logic [TAKEN_W-1:0] limit_q, limit_d;
  logic [TAKEN_W-1:0] cnt_q, cnt_d;
  logic [TAKEN_W-1:0] cnt_next;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      shifted;
  logic [BW-1:0]      bin;
  logic               accept;
  logic               is_sample;
  logic               take;
  logic               in_range;

  assign in_stall  = q_full_i || clearing_i;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // bin = (value * BIN_COUNT) >> SAMPLE_BITS
  assign prod     = PW'(in_data_i.sample_value[VW-1:0]) * PW'(BIN_COUNT);
  assign shifted  = prod >> SAMPLE_BITS;
  assign bin      = shifted[BW-1:0];
  assign in_range = 32'(in_data_i.bin_index) < BIN_COUNT;

  always_comb begin
    is_sample = in_data_i.action == ACTION_SAMPLE;
    take      = cnt_q < limit_q;
    cnt_next  = cnt_q + 16'd1;

    op_o.kind          = OP_ZERO;
    op_o.addr          = ADDR_W'(in_data_i.bin_index);
    op_o.samples_taken = cnt_q;
    op_o.done          = cnt_q >= limit_q;
    op_o.accepted      = 1'b0;
    if (is_sample) begin
      if (take) begin
        op_o.kind          = OP_INC;
        op_o.addr          = ADDR_W'(bin);
        op_o.samples_taken = cnt_next;
        op_o.done          = cnt_next >= limit_q;
        op_o.accepted      = 1'b1;
      end
    end else if (in_range) begin
      op_o.kind = OP_READ;
    end

    push_o  = accept;
    cnt_d   = (accept && is_sample && take) ? cnt_next : cnt_q;
    limit_d = cfg_valid ? cfg_data_i : limit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      cnt_q   <= '0;
    end else begin
      limit_q <= limit_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- design/phh_queue.sv -----
// ----------------------------------------------------------------------------
// phh_queue
// Two-entry queue of memory operations between front and back end.
// ----------------------------------------------------------------------------
module phh_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  phh_pkg::op_t data_i,
  input  logic         pop_i,
  output phh_pkg::op_t data_o,
  output logic         full_o,
  output logic         empty_o
);
  import phh_pkg::*;

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/phh_back.sv -----
// ----------------------------------------------------------------------------
// phh_back
// Bin memory with its clearing sweep, a read of one bin per operation with
// an incremented write-back for samples, and the output register.
// ----------------------------------------------------------------------------
module phh_back #(
  parameter int BIN_COUNT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  phh_pkg::op_t       q_head_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               out_valid,
  input  logic               out_stall,
  output phh_pkg::out_item_t out_data_o
);
  import phh_pkg::*;

  localparam int BW = $clog2(BIN_COUNT);

  back_state_e        state_q, state_d;
  logic [BW-1:0]      clr_idx_q, clr_idx_d;
  logic [COUNT_W-1:0] mem_q [BIN_COUNT];
  logic [COUNT_W-1:0] rd_q;
  op_t                op_q, op_d;
  logic               mem_we;
  logic [BW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               mem_re;
  logic [BW-1:0]      mem_raddr;
  logic [COUNT_W-1:0] cnt_inc;
  logic               wb_go;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;
  logic               out_load;

  assign clearing_o = state_q == B_CLEAR;
  assign out_valid  = out_valid_q;
  assign out_data_o = out_data_q;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    op_d        = op_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = op_q.addr[BW-1:0];
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = q_head_i.addr[BW-1:0];
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall;
    out_data_d  = out_data_q;
    // saturating increment
    cnt_inc     = (rd_q == COUNT_MAX) ? rd_q : rd_q + 32'd1;
    wb_go       = !(out_valid_q && out_stall);

    case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + BW'(1);
        if (clr_idx_q == BW'(BIN_COUNT - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          mem_re  = 1'b1;
          op_d    = q_head_i;
          state_d = B_WB;
        end
      end
      B_WB: begin
        // hold here until the output register is free
        if (wb_go) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
          if (op_q.kind == OP_INC) begin
            mem_we    = 1'b1;
            mem_wdata = cnt_inc;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d                 = 1'b1;
      out_data_d.samples_taken    = op_q.samples_taken;
      out_data_d.measurement_done = op_q.done;
      out_data_d.sample_accepted  = op_q.accepted;
      case (op_q.kind)
        OP_INC:  out_data_d.bin_count = cnt_inc;
        OP_READ: out_data_d.bin_count = rd_q;
        default: out_data_d.bin_count = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

endmodule

// ----- design/pulse_height_histogram.sv -----
// ----------------------------------------------------------------------------
// pulse_height_histogram
// Pulse-height histogram: converter samples are binned and counted with
// saturation until a sample limit is reached; bins can be read back.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one item: a converter sample
// (action 0) or a bin read (action 1). Output channel out_valid/out_stall
// returns one result item per input item, in order. The sample limit is
// written through cfg_valid/cfg_ready/cfg_data_i, which is always ready.
// The front end takes an item in any cycle the two-entry queue has room
// and no clear runs. The back end reads the bin in B_IDLE and, for a
// sample, writes it back in B_WB as it loads the output register;
// it takes no new item before it is through with the last. After reset
// the bin memory is swept to zero, one bin a cycle; in_stall is held
// high during that sweep while limit writes are still taken. The limit
// resets to 4 and the counter to 0. While out_stall is high the result
// holds in the output register; the queue then fills and in_stall rises
// until the receiver takes the item.
// ----------------------------------------------------------------------------
module pulse_height_histogram #(
  parameter int BIN_COUNT   = 256,
  parameter int SAMPLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  phh_pkg::in_item_t  in_data_i,
  output logic               out_valid,
  input  logic               out_stall,
  output phh_pkg::out_item_t out_data_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data_i
);
  import phh_pkg::*;

  logic push;
  logic pop;
  op_t  op_in;
  op_t  op_head;
  logic q_full;
  logic q_empty;
  logic clearing;

  phh_front #(
    .BIN_COUNT   (BIN_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_i  (in_data_i),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .op_o       (op_in)
  );

  phh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .pop_i   (pop),
    .data_o  (op_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  phh_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (op_head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_take_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall)
    else $error("item taken during memory clear");

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid)
    else $error("result shown during memory clear");

  a_accepted_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data_o.sample_accepted) |-> (out_data_o.samples_taken != 16'd0))
    else $error("accepted sample with zero sample count");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pulse-height histogram against its own bin store and sample
// counter: directed edge items first, then random runs under changing limits.
// ----------------------------------------------------------------------------
module testbench;
  import phh_pkg::*;

  localparam int BINS        = 256;
  localparam int SAMPLE_BITS = 10;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [TAKEN_W-1:0]   cfg_data;

  // own copy of the histogram state
  logic [COUNT_W-1:0]   bin_tally [BINS];
  logic [TAKEN_W-1:0]   taken_count;
  logic [TAKEN_W-1:0]   limit_now;
  out_item_t            pending_results [$];

  bit                   steady_pace;
  int                   errors;
  int                   samples_added;
  int                   samples_refused;
  int                   reads_sent;
  int                   limit_writes;
  int                   idle_cycles;

  pulse_height_histogram #(
    .BIN_COUNT   (BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_i  (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data_o (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic out_item_t predict_result(input in_item_t item);
    out_item_t   res;
    int unsigned slot;
    res = '0;
    if (item.action == ACTION_SAMPLE) begin
      if (taken_count < limit_now) begin
        slot = (int'(item.sample_value) * BINS) >> SAMPLE_BITS;
        if (slot < BINS) begin
          if (bin_tally[slot] != COUNT_MAX) begin
            bin_tally[slot] = bin_tally[slot] + 1'b1;
          end
          res.bin_count = bin_tally[slot];
        end
        taken_count = taken_count + 1'b1;
        res.sample_accepted = 1'b1;
      end
    end else if (item.bin_index < BINS) begin
      res.bin_count = bin_tally[item.bin_index];
    end
    res.samples_taken    = taken_count;
    res.measurement_done = (taken_count >= limit_now);
    return res;
  endfunction

  function automatic in_item_t sample_item(input logic [SAMPLE_W-1:0] value);
    in_item_t it;
    it              = '0;
    it.action       = ACTION_SAMPLE;
    it.sample_value = value;
    it.bin_index    = BIN_IDX_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [BIN_IDX_W-1:0] bin);
    in_item_t it;
    it              = '0;
    it.action       = ACTION_READ;
    it.sample_value = SAMPLE_W'($urandom);
    it.bin_index    = bin;
    return it;
  endfunction

  // valid stays high across back-to-back items, lowered only for a gap
  task automatic feed_item(input in_item_t item);
    int        gap;
    out_item_t res;
    gap = steady_pace ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    res = predict_result(item);
    pending_results.push_back(res);
    if (item.action == ACTION_READ) begin
      reads_sent++;
    end else if (res.sample_accepted) begin
      samples_added++;
    end else begin
      samples_refused++;
    end
  endtask

  // the limit is only changed once every result has come back
  task automatic write_limit(input logic [TAKEN_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    limit_now = value;
    limit_writes++;
  endtask

  task automatic test_after_reset();
    feed_item(read_item(8'd0));
    feed_item(read_item(8'd255));
  endtask

  // reset limit of 4: both ends of the converter range, then a refused sample
  task automatic test_bin_edges();
    feed_item(sample_item(10'd0));
    feed_item(sample_item(10'd3));
    feed_item(sample_item(10'd4));
    feed_item(sample_item(10'd1023));
    feed_item(sample_item(10'd512));
    feed_item(read_item(8'd0));
    feed_item(read_item(8'd255));
    feed_item(read_item(8'd1));
  endtask

  task automatic test_zero_limit();
    write_limit(16'd0);
    feed_item(sample_item(10'd1020));
    feed_item(read_item(8'd255));
  endtask

  // counter is kept across limit writes; a limit below it stops sampling
  task automatic test_limit_change();
    write_limit(16'd1);
    feed_item(sample_item(10'd7));
    write_limit(16'd6);
    feed_item(sample_item(10'h2AA));
    feed_item(sample_item(10'h155));
    feed_item(sample_item(10'h3FF));
    write_limit(16'hFFFF);
    feed_item(sample_item(10'd1023));
    feed_item(sample_item(10'd0));
    feed_item(read_item(8'd255));
    feed_item(read_item(8'd0));
  endtask

  task automatic test_random_runs(input int target);
    int       hot [4];
    int       base;
    int       roll;
    int       n;
    in_item_t it;
    base = samples_added + samples_refused + reads_sent;
    foreach (hot[k]) hot[k] = $urandom_range(0, BINS - 1);
    while (samples_added + samples_refused + reads_sent - base < target) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        write_limit(16'd0);
      end else if (roll == 1) begin
        write_limit(16'hFFFF);
      end else if (roll == 2 && taken_count > 0) begin
        write_limit(TAKEN_W'($urandom_range(1, taken_count)));
      end else begin
        write_limit(TAKEN_W'(taken_count + $urandom_range(5, 120)));
      end
      steady_pace = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 160);
      repeat (n) begin
        roll = $urandom_range(0, 9);
        // hot bins let some counts climb well above one
        if (roll < 4) begin
          it = sample_item(SAMPLE_W'(hot[$urandom_range(0, 3)] * 4 + $urandom_range(0, 3)));
        end else if (roll < 7) begin
          it = sample_item(SAMPLE_W'($urandom));
        end else if (roll < 9) begin
          it = read_item(BIN_IDX_W'(hot[$urandom_range(0, 3)]));
        end else begin
          it = read_item(BIN_IDX_W'($urandom));
        end
        feed_item(it);
      end
      hot[$urandom_range(0, 3)] = $urandom_range(0, BINS - 1);
      steady_pace = 1'b0;
    end
  endtask

  // result side: random stall after each result, none in steady stretches
  initial begin : result_side
    int        hold;
    out_item_t want;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result item arrived with nothing outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.bin_count !== want.bin_count) begin
            $error("bin_count: expected %0d, got %0d", want.bin_count, out_item.bin_count);
            errors++;
          end
          if (out_item.samples_taken !== want.samples_taken) begin
            $error("samples_taken: expected %0d, got %0d",
                   want.samples_taken, out_item.samples_taken);
            errors++;
          end
          if (out_item.measurement_done !== want.measurement_done) begin
            $error("measurement_done: expected %0b, got %0b",
                   want.measurement_done, out_item.measurement_done);
            errors++;
          end
          if (out_item.sample_accepted !== want.sample_accepted) begin
            $error("sample_accepted: expected %0b, got %0b",
                   want.sample_accepted, out_item.sample_accepted);
            errors++;
          end
        end
        hold = steady_pace ? 0 : $urandom_range(0, 3);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run
    errors          = 0;
    samples_added   = 0;
    samples_refused = 0;
    reads_sent      = 0;
    limit_writes    = 0;
    idle_cycles     = 0;
    steady_pace     = 1'b0;
    foreach (bin_tally[k]) bin_tally[k] = '0;
    taken_count = '0;
    limit_now   = LIMIT_RESET;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_bin_edges();
    test_zero_limit();
    test_limit_change();
    test_random_runs(1600);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d samples binned, %0d refused at the limit, %0d bin reads",
             samples_added, samples_refused, reads_sent);
    $display("limit register written %0d times, final sample count %0d, %0d mismatches",
             limit_writes, taken_count, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
